FILE: rtl/core/udp_socket_demux_table_top_assert.svh
// ----------------------------------------------------------------------------
// UDP socket demux table assertion macros
// Concurrent assertion helpers used by the controller RTL file of the block.
// ----------------------------------------------------------------------------
`ifndef UDP_SOCKET_DEMUX_TABLE_TOP_ASSERT_SVH
`define UDP_SOCKET_DEMUX_TABLE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define UDM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("udp demux assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define UDM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("udp demux assertion failed");
`else
`define UDM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define UDM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/udpdmx_pkg.sv
// ----------------------------------------------------------------------------
// UDP socket demux table package
// Sizes, codes and shared types of the socket table block.
// ----------------------------------------------------------------------------
package udpdmx_pkg;

	// Table geometry.
	localparam int SOCKET_COUNT    = 8;
	localparam int RX_BUFFER_BYTES = 1024;
	localparam int HEADER_BYTES    = 8;
	localparam int IDX_W = (SOCKET_COUNT > 1) ? $clog2(SOCKET_COUNT) : 1;
	localparam int LEN_W = $clog2(RX_BUFFER_BYTES + 1);

	// Field widths.
	localparam int KIND_W   = 3;
	localparam int SOCK_W   = 4;
	localparam int STATUS_W = 3;
	localparam int PORT_W   = 16;
	localparam int IP_W     = 32;
	localparam int CNT_W    = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [SOCK_W:0] SOCK_LIMIT = (SOCK_W + 1)'(SOCKET_COUNT);

	// Item kinds.
	localparam logic [KIND_W-1:0] KIND_OPEN  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_CLOSE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_BIND  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_RECV  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_POLL  = 3'd4;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_ERROR     = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_NODATA    = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_SHORT     = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_DHCP      = 3'd4;
	localparam logic [STATUS_W-1:0] STAT_DNS       = 3'd5;
	localparam logic [STATUS_W-1:0] STAT_UNMATCHED = 3'd6;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd7;

	// Configuration register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] REG_DHCP_PORT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DNS_PORT  = 1'd1;
	localparam logic [PORT_W-1:0] DHCP_PORT_RESET = 16'd68;
	localparam logic [PORT_W-1:0] DNS_PORT_RESET  = 16'd53;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;
		logic commit;
	} udpdmx_cmd_t;

	// Lowest set bit of an entry vector.
	function automatic logic [IDX_W-1:0] first_set(input logic [SOCKET_COUNT-1:0] v);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = SOCKET_COUNT - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = IDX_W'(i);
			end
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/udpdmx_ctrl.sv
// ----------------------------------------------------------------------------
// UDP socket demux controller
// Sequences item capture, table commit and result word handoff.
// ----------------------------------------------------------------------------
`include "udp_socket_demux_table_top_assert.svh"

module udpdmx_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  logic                    out_ready,
	output udpdmx_pkg::udpdmx_cmd_t cmd
);
	import udpdmx_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic state_d;
	logic out_valid_q;
	logic can_commit;
	logic in_fire;

	// Handshake decode; a commit needs room in the result register.
	assign in_ready   = (state_q == S_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign can_commit = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;

	assign cmd.load_item = in_fire;
	assign cmd.commit    = can_commit;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (can_commit) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (can_commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`UDM_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_fire, !in_ready)
	`UDM_ASSERT_NXT(a_result_after_commit, clk, arst_n, can_commit, out_valid_q)
	`UDM_ASSERT_IMP(a_no_overwrite, clk, arst_n, can_commit && out_valid_q, out_ready)
	`UDM_ASSERT_IMP(a_commit_only_busy, clk, arst_n, can_commit, !in_ready)

endmodule

FILE: rtl/core/udpdmx_datapath.sv
// ----------------------------------------------------------------------------
// UDP socket demux datapath
// Socket table, item registers, lookup logic and the result register.
// ----------------------------------------------------------------------------
module udpdmx_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  udpdmx_pkg::udpdmx_cmd_t             cmd,
	input  logic                                cfg_we,
	input  logic [udpdmx_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [udpdmx_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic [udpdmx_pkg::KIND_W-1:0]       kind,
	input  logic [udpdmx_pkg::SOCK_W-1:0]       socket_index,
	input  logic [udpdmx_pkg::PORT_W-1:0]       open_port,
	input  logic [udpdmx_pkg::IP_W-1:0]         filter_ip,
	input  logic [udpdmx_pkg::PORT_W-1:0]       filter_port,
	input  logic [udpdmx_pkg::IP_W-1:0]         sender_ip,
	input  logic [udpdmx_pkg::PORT_W-1:0]       sender_port,
	input  logic [udpdmx_pkg::PORT_W-1:0]       target_port,
	input  logic [udpdmx_pkg::CNT_W-1:0]        frame_len,
	input  logic [udpdmx_pkg::CNT_W-1:0]        udp_length,
	input  logic [udpdmx_pkg::CNT_W-1:0]        recv_limit,
	output logic [udpdmx_pkg::STATUS_W-1:0]     status,
	output logic [udpdmx_pkg::SOCK_W-1:0]       entry_out,
	output logic [udpdmx_pkg::CNT_W-1:0]        byte_count,
	output logic [udpdmx_pkg::IP_W-1:0]         from_ip,
	output logic [udpdmx_pkg::PORT_W-1:0]       peer_port
);
	import udpdmx_pkg::*;

	// Configuration registers.
	logic [PORT_W-1:0] dhcp_port_q;
	logic [PORT_W-1:0] dns_srv_port_q;

	// Captured item.
	logic [KIND_W-1:0] kind_q;
	logic [SOCK_W-1:0] idx_q;
	logic [PORT_W-1:0] lport_q;
	logic [IP_W-1:0]   fip_q;
	logic [PORT_W-1:0] fport_q;
	logic [IP_W-1:0]   sip_q;
	logic [PORT_W-1:0] sport_q;
	logic [PORT_W-1:0] tport_q;
	logic [CNT_W-1:0]  flen_q;
	logic [CNT_W-1:0]  ulen_q;
	logic [CNT_W-1:0]  limit_q;

	// Socket table.
	logic [SOCKET_COUNT-1:0] used_q;
	logic [SOCKET_COUNT-1:0] pending_q;
	logic [PORT_W-1:0] lport_tab_q [SOCKET_COUNT];
	logic [IP_W-1:0]   fip_tab_q   [SOCKET_COUNT];
	logic [PORT_W-1:0] fport_tab_q [SOCKET_COUNT];
	logic [LEN_W-1:0]  len_tab_q   [SOCKET_COUNT];
	logic [IP_W-1:0]   sip_tab_q   [SOCKET_COUNT];
	logic [PORT_W-1:0] sport_tab_q [SOCKET_COUNT];

	// Result register.
	logic [STATUS_W-1:0] status_q;
	logic [SOCK_W-1:0]   entry_q;
	logic [CNT_W-1:0]    count_q;
	logic [IP_W-1:0]     rip_q;
	logic [PORT_W-1:0]   rport_q;

	// Lookup signals.
	logic                    idx_ok;
	logic [IDX_W-1:0]        sel;
	logic [SOCKET_COUNT-1:0] match;
	logic [IDX_W-1:0]        free_idx;
	logic [IDX_W-1:0]        hit_idx;
	logic [CNT_W-1:0]        plen;
	logic [LEN_W-1:0]        plen_cap;
	logic [CNT_W-1:0]        stored_len;
	logic [CNT_W-1:0]        poll_len;

	// Next result and table actions.
	logic [STATUS_W-1:0] res_status;
	logic [SOCK_W-1:0]   res_entry;
	logic [CNT_W-1:0]    res_count;
	logic [IP_W-1:0]     res_ip;
	logic [PORT_W-1:0]   res_port;
	logic do_open;
	logic do_close;
	logic do_bind;
	logic do_store;
	logic do_poll;

	// Configuration writes are taken in any cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dhcp_port_q    <= DHCP_PORT_RESET;
			dns_srv_port_q <= DNS_PORT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DHCP_PORT: dhcp_port_q    <= cfg_wdata;
				REG_DNS_PORT:  dns_srv_port_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Item capture on input accept.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q  <= kind;
			idx_q   <= socket_index;
			lport_q <= open_port;
			fip_q   <= filter_ip;
			fport_q <= filter_port;
			sip_q   <= sender_ip;
			sport_q <= sender_port;
			tport_q <= target_port;
			flen_q  <= frame_len;
			ulen_q  <= udp_length;
			limit_q <= recv_limit;
		end
	end

	// Addressed entry and parallel match against every entry.
	assign idx_ok = ({1'b0, idx_q} < SOCK_LIMIT);
	assign sel    = idx_q[IDX_W-1:0];

	always_comb begin
		for (int i = 0; i < SOCKET_COUNT; i++) begin
			match[i] = used_q[i] && (lport_tab_q[i] == tport_q)
				&& ((fip_tab_q[i] == '0) || (fip_tab_q[i] == sip_q))
				&& ((fport_tab_q[i] == '0) || (fport_tab_q[i] == sport_q));
		end
	end

	assign free_idx = first_set(~used_q);
	assign hit_idx  = first_set(match);

	// Payload length wraps, then is capped to the buffer size.
	assign plen     = ulen_q - CNT_W'(HEADER_BYTES);
	assign plen_cap = (plen > CNT_W'(RX_BUFFER_BYTES)) ? LEN_W'(RX_BUFFER_BYTES)
		: plen[LEN_W-1:0];

	// Poll length is capped to the caller's limit.
	assign stored_len = CNT_W'(len_tab_q[sel]);
	assign poll_len   = (stored_len > limit_q) ? limit_q : stored_len;

	// Decide the result and the table update for the captured item.
	always_comb begin
		res_status = STAT_ERROR;
		res_entry  = '0;
		res_count  = '0;
		res_ip     = '0;
		res_port   = '0;
		do_open    = 1'b0;
		do_close   = 1'b0;
		do_bind    = 1'b0;
		do_store   = 1'b0;
		do_poll    = 1'b0;
		case (kind_q)
			KIND_OPEN: begin
				if (&used_q) begin
					res_status = STAT_FULL;
				end else begin
					res_status = STAT_OK;
					res_entry  = SOCK_W'(free_idx);
					do_open    = 1'b1;
				end
			end
			KIND_CLOSE: begin
				if (idx_ok) begin
					res_status = STAT_OK;
					do_close   = 1'b1;
				end
			end
			KIND_BIND: begin
				if (idx_ok && used_q[sel]) begin
					res_status = STAT_OK;
					do_bind    = 1'b1;
				end
			end
			KIND_RECV: begin
				if (flen_q < CNT_W'(HEADER_BYTES)) begin
					res_status = STAT_SHORT;
				end else if (tport_q == dhcp_port_q) begin
					res_status = STAT_DHCP;
				end else if (sport_q == dns_srv_port_q) begin
					res_status = STAT_DNS;
				end else if (match == '0) begin
					res_status = STAT_UNMATCHED;
				end else begin
					res_status = STAT_OK;
					res_entry  = SOCK_W'(hit_idx);
					res_count  = CNT_W'(plen_cap);
					do_store   = 1'b1;
				end
			end
			KIND_POLL: begin
				if (idx_ok && used_q[sel]) begin
					res_entry = idx_q;
					if (!pending_q[sel]) begin
						res_status = STAT_NODATA;
					end else begin
						res_status = STAT_OK;
						res_count  = poll_len;
						res_ip     = sip_tab_q[sel];
						res_port   = sport_tab_q[sel];
						do_poll    = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Table update on commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			pending_q <= '0;
			for (int i = 0; i < SOCKET_COUNT; i++) begin
				lport_tab_q[i] <= '0;
				fip_tab_q[i]   <= '0;
				fport_tab_q[i] <= '0;
				len_tab_q[i]   <= '0;
				sip_tab_q[i]   <= '0;
				sport_tab_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			if (do_open) begin
				used_q[free_idx]      <= 1'b1;
				pending_q[free_idx]   <= 1'b0;
				lport_tab_q[free_idx] <= lport_q;
				fip_tab_q[free_idx]   <= '0;
				fport_tab_q[free_idx] <= '0;
				len_tab_q[free_idx]   <= '0;
				sip_tab_q[free_idx]   <= '0;
				sport_tab_q[free_idx] <= '0;
			end
			if (do_close) begin
				used_q[sel] <= 1'b0;
			end
			if (do_bind) begin
				fip_tab_q[sel]   <= fip_q;
				fport_tab_q[sel] <= fport_q;
			end
			if (do_store) begin
				pending_q[hit_idx]   <= 1'b1;
				len_tab_q[hit_idx]   <= plen_cap;
				sip_tab_q[hit_idx]   <= sip_q;
				sport_tab_q[hit_idx] <= sport_q;
			end
			if (do_poll) begin
				pending_q[sel] <= 1'b0;
			end
		end
	end

	// Result word register.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= res_status;
			entry_q  <= res_entry;
			count_q  <= res_count;
			rip_q    <= res_ip;
			rport_q  <= res_port;
		end
	end

	assign status     = status_q;
	assign entry_out  = entry_q;
	assign byte_count = count_q;
	assign from_ip    = rip_q;
	assign peer_port  = rport_q;

endmodule

FILE: rtl/core/udp_socket_demux_table_top.sv
// ----------------------------------------------------------------------------
// UDP socket demux table
// Socket table that opens, closes, binds, steers received headers and polls.
// ----------------------------------------------------------------------------
// Usage:
// Each input word carries one socket call or one received UDP header, with
// its kind and all fields; it is taken when in_valid and in_ready are high.
// Every input word yields exactly one output word on out_valid/out_ready.
// The word is captured into the item registers at the accepting edge, the
// whole table is looked up in parallel, and the commit edge updates the
// table together with the result register, which raises out_valid. No new
// word is taken until the controller has committed the previous one.
// A new word is accepted while the previous result still waits in the output
// register, but the next commit holds until that result is taken, so a
// stalled receiver stalls the input after one word. Reset clears every table
// entry, loads the DHCP client port with 68 and the DNS server port with 53,
// and leaves no result pending. The user writes the two port registers via
// cfg_we, cfg_index and cfg_wdata only while idle, which is not enforced.
// ----------------------------------------------------------------------------
module udp_socket_demux_table_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [udpdmx_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [udpdmx_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [udpdmx_pkg::KIND_W-1:0]       kind,
	input  logic [udpdmx_pkg::SOCK_W-1:0]       socket_index,
	input  logic [udpdmx_pkg::PORT_W-1:0]       open_port,
	input  logic [udpdmx_pkg::IP_W-1:0]         filter_ip,
	input  logic [udpdmx_pkg::PORT_W-1:0]       filter_port,
	input  logic [udpdmx_pkg::IP_W-1:0]         sender_ip,
	input  logic [udpdmx_pkg::PORT_W-1:0]       sender_port,
	input  logic [udpdmx_pkg::PORT_W-1:0]       target_port,
	input  logic [udpdmx_pkg::CNT_W-1:0]        frame_len,
	input  logic [udpdmx_pkg::CNT_W-1:0]        udp_length,
	input  logic [udpdmx_pkg::CNT_W-1:0]        recv_limit,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [udpdmx_pkg::STATUS_W-1:0]     status,
	output logic [udpdmx_pkg::SOCK_W-1:0]       entry_out,
	output logic [udpdmx_pkg::CNT_W-1:0]        byte_count,
	output logic [udpdmx_pkg::IP_W-1:0]         from_ip,
	output logic [udpdmx_pkg::PORT_W-1:0]       peer_port
);
	import udpdmx_pkg::*;

	udpdmx_cmd_t cmd;

	// Controller: handshakes and commit sequencing.
	udpdmx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Datapath: table, lookup and result register.
	udpdmx_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.kind         (kind),
		.socket_index (socket_index),
		.open_port    (open_port),
		.filter_ip    (filter_ip),
		.filter_port  (filter_port),
		.sender_ip    (sender_ip),
		.sender_port  (sender_port),
		.target_port  (target_port),
		.frame_len    (frame_len),
		.udp_length   (udp_length),
		.recv_limit   (recv_limit),
		.status       (status),
		.entry_out    (entry_out),
		.byte_count   (byte_count),
		.from_ip      (from_ip),
		.peer_port    (peer_port)
	);

endmodule
